>>> src/lrud_pkg.sv
package lrud_pkg;

    // Default directory size and fixed field widths
    localparam int SLOTS_DEF  = 64;
    localparam int CAP_W      = 7;
    localparam int TEXT_W     = 32;
    localparam int FACE_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int STAMP_W    = 64;
    localparam int SLOT_W     = 6;
    localparam int IN_DATA_W  = TEXT_W + FACE_W + SIZE_W;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes carried in s_axis_tuser
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // Lookup key, text tag in the lowest bits
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [FACE_W-1:0] face;
        logic [TEXT_W-1:0] text;
    } key_t;

    // Store control from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_key;
        logic wr_stamp;
        logic set_valid;
        logic clr_all;
    } mem_ctl_t;

    // One registered read of the store
    typedef struct packed {
        logic               valid;
        key_t               key;
        logic [STAMP_W-1:0] stamp;
    } rd_data_t;

    // Running scan results
    typedef struct packed {
        logic found;
        logic any;
        logic free_found;
    } scan_flags_t;

    // Result flags, hit in bit 0
    typedef struct packed {
        logic evicted;
        logic hit;
    } res_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

>>> src/lru_tagged_cache_directory.sv
// Fully associative cache directory with least-recently-used replacement.
// s_axis: tuser = operation (lookup-or-insert, or clear all entries),
//   tdata = lookup key {size in sixteenths, typeface id, text tag}.
// m_axis: one item per input item; tdata = slot, tuser = {evicted, hit}.
// cfg_we/cfg_wdata: capacity register, to be written by the user only while
// the block is idle; the block itself has no check for this.
// A lookup is accepted in idle, then the single compare unit reads one slot
// per cycle from the key and stamp memories, the drain state takes the last
// read, the decide state decides and writes back, and the done state loads
// the result once the output register is free.
// A clear goes from idle straight to the done state to load its result.
// One item is worked on at a time; s_axis_tready is high only while the
// sequencer is idle.
// The result sits in an output register; a stalled receiver holds it and
// the next item may be accepted and scanned meanwhile, but its result
// waits until the register is taken.
// Reset clears all valid bits, the entry count and the use counter, and
// sets capacity to 64. Key and stamp memories are not cleared.
module lru_tagged_cache_directory
    import lrud_pkg::*;
#(
    parameter int  SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int CNT_W = $clog2(SLOTS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // text_key, typeface_id, size_sixteenths
    input  logic                  s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot, zero pad
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // hit, evicted
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata
);

    logic [CAP_W-1:0]  cap_reg;
    logic              m_tvalid_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    res_flags_t        m_flags_reg;

    mem_ctl_t           ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    key_t               wr_key;
    logic [STAMP_W-1:0] wr_stamp;
    logic               rd_vld;
    logic [IDX_W-1:0]   rd_idx;
    rd_data_t           rd;
    scan_flags_t        flags;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   old_idx;
    logic [IDX_W-1:0]   free_idx;
    logic               scan_init;
    logic               out_free;
    logic               res_load;
    res_flags_t         res_flags;
    logic [IDX_W-1:0]   res_slot;
    logic [CNT_W-1:0]   valid_count;
    key_t               in_key;

    assign in_key   = key_t'(s_axis_tdata);
    assign out_free = !m_tvalid_reg || m_axis_tready;

    lrud_store #(.SLOTS(SLOTS)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_stamp (wr_stamp),
        .rd_vld   (rd_vld),
        .rd_idx   (rd_idx),
        .rd       (rd)
    );

    lrud_scan #(.SLOTS(SLOTS)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (scan_init),
        .rd_vld    (rd_vld),
        .rd_idx    (rd_idx),
        .rd        (rd),
        .key       (wr_key),
        .flags     (flags),
        .match_idx (match_idx),
        .old_idx   (old_idx),
        .free_idx  (free_idx)
    );

    lrud_seq #(.SLOTS(SLOTS)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_func     (s_axis_tuser),
        .in_key      (in_key),
        .in_ready    (s_axis_tready),
        .cap         (cap_reg),
        .out_free    (out_free),
        .flags       (flags),
        .match_idx   (match_idx),
        .old_idx     (old_idx),
        .free_idx    (free_idx),
        .scan_init   (scan_init),
        .ctl         (ctl),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_key      (wr_key),
        .wr_stamp    (wr_stamp),
        .res_load    (res_load),
        .res_flags   (res_flags),
        .res_slot    (res_slot),
        .valid_count (valid_count)
    );

    // Capacity register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (res_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_slot_reg  <= SLOT_W'(res_slot);
            m_flags_reg <= res_flags;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(m_slot_reg);
    assign m_axis_tuser  = m_flags_reg;

    // A hit never evicts
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit and evicted both set");

    // Entry count stays within the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(valid_count) <= 32'(SLOTS))
        else $error("valid count above slot count");

    // One item in flight: not ready right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after accept");

    // A result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!m_tvalid_reg || m_axis_tready))
        else $error("result loaded over pending item");

endmodule

>>> src/lrud_store.sv
module lrud_store
    import lrud_pkg::*;
#(
    parameter int  SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mem_ctl_t           ctl,
    input  logic [IDX_W-1:0]   rd_addr,
    input  logic [IDX_W-1:0]   wr_addr,
    input  key_t               wr_key,
    input  logic [STAMP_W-1:0] wr_stamp,
    output logic               rd_vld,
    output logic [IDX_W-1:0]   rd_idx,
    output rd_data_t           rd
);

    key_t               key_mem   [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;

    key_t               rd_key_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_vld_reg;

    // Key memory
    always_ff @(posedge clk)
    begin
        if (ctl.wr_key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
        end
    end

    // Use stamp memory
    always_ff @(posedge clk)
    begin
        if (ctl.wr_stamp)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (ctl.rd_en)
        begin
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    // Valid bit and index sampled with the read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    // Valid bits: cleared at once by reset or clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= ctl.rd_en;
            if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_vld   = rd_vld_reg;
    assign rd_idx   = rd_idx_reg;
    assign rd.valid = rd_valid_reg;
    assign rd.key   = rd_key_reg;
    assign rd.stamp = rd_stamp_reg;

endmodule

>>> src/lrud_scan.sv
module lrud_scan
    import lrud_pkg::*;
#(
    parameter int  SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             init,
    input  logic             rd_vld,
    input  logic [IDX_W-1:0] rd_idx,
    input  rd_data_t         rd,
    input  key_t             key,
    output scan_flags_t      flags,
    output logic [IDX_W-1:0] match_idx,
    output logic [IDX_W-1:0] old_idx,
    output logic [IDX_W-1:0] free_idx
);

    scan_flags_t        flags_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [IDX_W-1:0]   old_idx_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [STAMP_W-1:0] old_stamp_reg;

    logic key_eq;
    logic stamp_lt;
    logic take_match;
    logic take_old;
    logic take_free;

    // Shared compare unit: key equality and stamp order
    assign key_eq   = (rd.key == key);
    assign stamp_lt = (rd.stamp < old_stamp_reg);

    // Lowest matching slot, oldest valid slot (lowest on ties), lowest free slot
    assign take_match = rd_vld && rd.valid && key_eq && !flags_reg.found;
    assign take_old   = rd_vld && rd.valid && (!flags_reg.any || stamp_lt);
    assign take_free  = rd_vld && !rd.valid && !flags_reg.free_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (init)
        begin
            flags_reg <= '0;
        end
        else
        begin
            if (take_match)
            begin
                flags_reg.found <= 1'b1;
            end
            if (take_old)
            begin
                flags_reg.any <= 1'b1;
            end
            if (take_free)
            begin
                flags_reg.free_found <= 1'b1;
            end
        end
    end

    // Index and stamp payload
    always_ff @(posedge clk)
    begin
        if (!init)
        begin
            if (take_match)
            begin
                match_idx_reg <= rd_idx;
            end
            if (take_old)
            begin
                old_idx_reg   <= rd_idx;
                old_stamp_reg <= rd.stamp;
            end
            if (take_free)
            begin
                free_idx_reg <= rd_idx;
            end
        end
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign old_idx   = old_idx_reg;
    assign free_idx  = free_idx_reg;

endmodule

>>> src/lrud_seq.sv
module lrud_seq
    import lrud_pkg::*;
#(
    parameter int  SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int CNT_W = $clog2(SLOTS + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_func,
    input  key_t               in_key,
    output logic               in_ready,
    input  logic [CAP_W-1:0]   cap,
    input  logic               out_free,
    input  scan_flags_t        flags,
    input  logic [IDX_W-1:0]   match_idx,
    input  logic [IDX_W-1:0]   old_idx,
    input  logic [IDX_W-1:0]   free_idx,
    output logic               scan_init,
    output mem_ctl_t           ctl,
    output logic [IDX_W-1:0]   rd_addr,
    output logic [IDX_W-1:0]   wr_addr,
    output key_t               wr_key,
    output logic [STAMP_W-1:0] wr_stamp,
    output logic               res_load,
    output res_flags_t         res_flags,
    output logic [IDX_W-1:0]   res_slot,
    output logic [CNT_W-1:0]   valid_count
);

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   scan_idx_reg;
    key_t               key_reg;
    logic [STAMP_W-1:0] counter_reg;
    logic [CNT_W-1:0]   count_reg;
    res_flags_t         res_flags_reg;
    logic [IDX_W-1:0]   res_slot_reg;

    logic             in_fire;
    logic             scan_last;
    logic [CNT_W-1:0] eff_cap;
    logic             full;
    logic             evict;
    logic             new_entry;
    logic [IDX_W-1:0] slot_sel;

    assign in_fire   = in_valid && (state_reg == ST_IDLE);
    assign scan_last = (scan_idx_reg == IDX_W'(SLOTS - 1));

    // Capacity: zero counts as one, saturates at the slot count
    always_comb
    begin
        if (cap == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(cap) > 32'(SLOTS))
        begin
            eff_cap = CNT_W'(SLOTS);
        end
        else
        begin
            eff_cap = CNT_W'(cap);
        end
    end

    // Replacement decision from the finished scan
    assign full      = (count_reg >= eff_cap);
    assign evict     = !flags.found && full && flags.any;
    assign new_entry = !flags.found && !evict;

    always_comb
    begin
        priority if (flags.found)
        begin
            slot_sel = match_idx;
        end
        else if (evict)
        begin
            slot_sel = old_idx;
        end
        else if (flags.free_found)
        begin
            slot_sel = free_idx;
        end
        else
        begin
            slot_sel = '0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_func == FUNC_CLEAR) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready  = 1'b0;
        scan_init = 1'b0;
        res_load  = 1'b0;
        ctl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                scan_init   = in_valid;
                ctl.clr_all = in_valid && (in_func == FUNC_CLEAR);
            end
            ST_SCAN:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_DECIDE:
            begin
                ctl.wr_stamp  = 1'b1;
                ctl.wr_key    = !flags.found;
                ctl.set_valid = new_entry;
            end
            ST_DONE:
            begin
                res_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            counter_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && (in_func == FUNC_CLEAR))
            begin
                count_reg <= '0;
            end
            else if ((state_reg == ST_DECIDE) && new_entry)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == ST_DECIDE)
            begin
                counter_reg <= counter_reg + STAMP_W'(1);
            end
        end
    end

    // Item payload, scan address and result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg      <= in_key;
            scan_idx_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end

        if (in_fire && (in_func == FUNC_CLEAR))
        begin
            res_flags_reg <= '0;
            res_slot_reg  <= '0;
        end
        else if (state_reg == ST_DECIDE)
        begin
            res_flags_reg.hit     <= flags.found;
            res_flags_reg.evicted <= evict;
            res_slot_reg          <= slot_sel;
        end
    end

    assign rd_addr     = scan_idx_reg;
    assign wr_addr     = slot_sel;
    assign wr_key      = key_reg;
    assign wr_stamp    = counter_reg + STAMP_W'(1);
    assign res_flags   = res_flags_reg;
    assign res_slot    = res_slot_reg;
    assign valid_count = count_reg;

endmodule
